FILE: rtl/core/line_segment_intersection_defines.svh
// Assertion macros shared by the checker of the line segment intersection block.
// No dependencies; include this file by its bare name.
`ifndef LINE_SEGMENT_INTERSECTION_DEFINES_SVH
`define LINE_SEGMENT_INTERSECTION_DEFINES_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is low.
`define LSI_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is also checked while reset is asserted.
`define LSI_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/lsi_pkg.sv
// Package of the line segment intersection block: sizes, derived widths and stage types.
// No dependencies; used by every module of the block.
package lsi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int POINT_BITS = 40;

    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int CROSS_W  = 2 * COORD_BITS + 1;
    localparam int DPROD_W  = 2 * DIFF_W;
    localparam int DET_W    = DPROD_W + 1;
    localparam int SPROD_W  = DIFF_W + COORD_BITS;
    localparam int SPART_W  = SPROD_W + 1;
    localparam int SIDE_W   = ((SPART_W > CROSS_W) ? SPART_W : CROSS_W) + 1;
    localparam int NPROD_W  = CROSS_W + DIFF_W;
    localparam int NUM_W    = NPROD_W + 1;
    localparam int SHIFT_W  = NUM_W + FRAC_BITS;
    localparam int EXT_W    = (SHIFT_W > POINT_BITS) ? SHIFT_W : POINT_BITS + 1;
    localparam int HI_W     = EXT_W - POINT_BITS;
    localparam int CMP_W    = (HI_W > DET_W) ? HI_W : DET_W;

    localparam logic [1:0] CMD_SEG_SEG  = 2'd0;
    localparam logic [1:0] CMD_SEG_LINE = 2'd1;
    localparam logic [1:0] CMD_LINE_LINE = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [POINT_BITS-1:0]        point_t;
    typedef logic [DET_W-1:0]             dmag_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } ctrl_t;

    typedef struct packed {
        logic [DET_W-1:0]      rem;
        logic [POINT_BITS-1:0] low;
        logic [POINT_BITS-1:0] quo;
        logic                  ovf;
        logic                  neg;
    } lane_t;

endpackage

FILE: rtl/core/lsi_prep.sv
// Front pipeline: differences, cross products, side tests, numerators and divider setup.
// Depends on lsi_pkg.
module lsi_prep (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [1:0]      command,
    input  lsi_pkg::coord_t first_start_x,
    input  lsi_pkg::coord_t first_start_y,
    input  lsi_pkg::coord_t first_end_x,
    input  lsi_pkg::coord_t first_end_y,
    input  lsi_pkg::coord_t second_start_x,
    input  lsi_pkg::coord_t second_start_y,
    input  lsi_pkg::coord_t second_end_x,
    input  lsi_pkg::coord_t second_end_y,
    output lsi_pkg::ctrl_t  ctrl,
    output lsi_pkg::dmag_t  dmag,
    output lsi_pkg::lane_t  lane_x,
    output lsi_pkg::lane_t  lane_y
);
    import lsi_pkg::*;

    logic [4:0] v_reg;

    logic [1:0] cmd1_reg;
    coord_t x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg, x4_reg, y4_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [DIFF_W-1:0] dx1_next, dy1_next, dx2_next, dy2_next;

    logic [1:0] cmd2_reg;
    logic signed [DIFF_W-1:0] dx1_2_reg, dy1_2_reg, dx2_2_reg, dy2_2_reg;
    logic signed [DPROD_W-1:0] pda_reg, pdb_reg, pda_next, pdb_next;
    logic signed [2*COORD_BITS-1:0] c1a_reg, c1b_reg, c2a_reg, c2b_reg;
    logic signed [2*COORD_BITS-1:0] c1a_next, c1b_next, c2a_next, c2b_next;
    logic signed [SPROD_W-1:0] s1a_reg, s1b_reg, s1c_reg, s1d_reg;
    logic signed [SPROD_W-1:0] s2a_reg, s2b_reg, s2c_reg, s2d_reg;
    logic signed [SPROD_W-1:0] s1a_next, s1b_next, s1c_next, s1d_next;
    logic signed [SPROD_W-1:0] s2a_next, s2b_next, s2c_next, s2d_next;

    logic [1:0] cmd3_reg;
    logic signed [DIFF_W-1:0] dx1_3_reg, dy1_3_reg, dx2_3_reg, dy2_3_reg;
    logic signed [DET_W-1:0] det3_reg, det3_next;
    logic signed [CROSS_W-1:0] c1_reg, c2_reg, c1_next, c2_next;
    logic signed [SPART_W-1:0] e1a_reg, e1b_reg, e2a_reg, e2b_reg;
    logic signed [SPART_W-1:0] e1a_next, e1b_next, e2a_next, e2b_next;

    logic [1:0] cmd4_reg;
    logic signed [DET_W-1:0] det4_reg;
    logic signed [SIDE_W-1:0] f1a_reg, f1b_reg, f2a_reg, f2b_reg;
    logic signed [SIDE_W-1:0] f1a_next, f1b_next, f2a_next, f2b_next;
    logic signed [NPROD_W-1:0] nxa_reg, nxb_reg, nya_reg, nyb_reg;
    logic signed [NPROD_W-1:0] nxa_next, nxb_next, nya_next, nyb_next;

    logic hit5_reg, hit5_next;
    logic signed [DET_W-1:0] det5_reg;
    logic signed [NUM_W-1:0] numx_reg, numy_reg, numx_next, numy_next;

    ctrl_t ctrl_reg, ctrl_next;
    dmag_t dmag_reg, dmag_next;
    lane_t lane_x_reg, lane_y_reg, lane_x_next, lane_y_next;

    logic same1, same2;

    function automatic lane_t setup(logic signed [NUM_W-1:0] num, logic det_neg,
                                    dmag_t d);
        logic [NUM_W-1:0] mag;
        logic [EXT_W-1:0] m;
        logic [HI_W-1:0]  hi;
        logic [CMP_W-1:0] hi_c;
        lane_t r;
        mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        m = EXT_W'(mag) << FRAC_BITS;
        hi = m[EXT_W-1:POINT_BITS];
        hi_c = CMP_W'(hi);
        r.ovf = hi_c >= CMP_W'(d);
        r.rem = hi_c[DET_W-1:0];
        r.low = m[POINT_BITS-1:0];
        r.quo = '0;
        r.neg = num[NUM_W-1] ^ det_neg;
        return r;
    endfunction

    function automatic logic same_side(logic signed [SIDE_W-1:0] p,
                                       logic signed [SIDE_W-1:0] q);
        return (p > 0 && q > 0) || (p < 0 && q < 0);
    endfunction

    always_comb
    begin
        dx1_next = DIFF_W'(first_start_x) - DIFF_W'(first_end_x);
        dy1_next = DIFF_W'(first_start_y) - DIFF_W'(first_end_y);
        dx2_next = DIFF_W'(second_start_x) - DIFF_W'(second_end_x);
        dy2_next = DIFF_W'(second_start_y) - DIFF_W'(second_end_y);

        pda_next = dx1_reg * dy2_reg;
        pdb_next = dy1_reg * dx2_reg;
        c1a_next = x1_reg * y2_reg;
        c1b_next = y1_reg * x2_reg;
        c2a_next = x3_reg * y4_reg;
        c2b_next = y3_reg * x4_reg;
        s1a_next = dy2_reg * x1_reg;
        s1b_next = dx2_reg * y1_reg;
        s1c_next = dy2_reg * x2_reg;
        s1d_next = dx2_reg * y2_reg;
        s2a_next = dy1_reg * x3_reg;
        s2b_next = dx1_reg * y3_reg;
        s2c_next = dy1_reg * x4_reg;
        s2d_next = dx1_reg * y4_reg;

        det3_next = DET_W'(pda_reg) - DET_W'(pdb_reg);
        c1_next = CROSS_W'(c1a_reg) - CROSS_W'(c1b_reg);
        c2_next = CROSS_W'(c2a_reg) - CROSS_W'(c2b_reg);
        e1a_next = SPART_W'(s1a_reg) - SPART_W'(s1b_reg);
        e1b_next = SPART_W'(s1c_reg) - SPART_W'(s1d_reg);
        e2a_next = SPART_W'(s2a_reg) - SPART_W'(s2b_reg);
        e2b_next = SPART_W'(s2c_reg) - SPART_W'(s2d_reg);

        f1a_next = SIDE_W'(e1a_reg) + SIDE_W'(c2_reg);
        f1b_next = SIDE_W'(e1b_reg) + SIDE_W'(c2_reg);
        f2a_next = SIDE_W'(e2a_reg) + SIDE_W'(c1_reg);
        f2b_next = SIDE_W'(e2b_reg) + SIDE_W'(c1_reg);
        nxa_next = c1_reg * dx2_3_reg;
        nxb_next = dx1_3_reg * c2_reg;
        nya_next = c1_reg * dy2_3_reg;
        nyb_next = dy1_3_reg * c2_reg;

        same1 = same_side(f1a_reg, f1b_reg);
        same2 = same_side(f2a_reg, f2b_reg);
        hit5_next = (det4_reg != 0)
            && !((cmd4_reg == CMD_SEG_SEG || cmd4_reg == CMD_SEG_LINE) && same1)
            && !((cmd4_reg == CMD_SEG_SEG) && same2);
        numx_next = NUM_W'(nxa_reg) - NUM_W'(nxb_reg);
        numy_next = NUM_W'(nya_reg) - NUM_W'(nyb_reg);

        dmag_next = det5_reg[DET_W-1] ? DET_W'(-det5_reg) : DET_W'(det5_reg);
        ctrl_next.valid = v_reg[4];
        ctrl_next.hit = hit5_reg;
        lane_x_next = setup(numx_reg, det5_reg[DET_W-1], dmag_next);
        lane_y_next = setup(numy_reg, det5_reg[DET_W-1], dmag_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            ctrl_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], in_valid};
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg <= command;
            x1_reg <= first_start_x;
            y1_reg <= first_start_y;
            x2_reg <= first_end_x;
            y2_reg <= first_end_y;
            x3_reg <= second_start_x;
            y3_reg <= second_start_y;
            x4_reg <= second_end_x;
            y4_reg <= second_end_y;
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
            dx2_reg <= dx2_next;
            dy2_reg <= dy2_next;

            cmd2_reg <= cmd1_reg;
            dx1_2_reg <= dx1_reg;
            dy1_2_reg <= dy1_reg;
            dx2_2_reg <= dx2_reg;
            dy2_2_reg <= dy2_reg;
            pda_reg <= pda_next;
            pdb_reg <= pdb_next;
            c1a_reg <= c1a_next;
            c1b_reg <= c1b_next;
            c2a_reg <= c2a_next;
            c2b_reg <= c2b_next;
            s1a_reg <= s1a_next;
            s1b_reg <= s1b_next;
            s1c_reg <= s1c_next;
            s1d_reg <= s1d_next;
            s2a_reg <= s2a_next;
            s2b_reg <= s2b_next;
            s2c_reg <= s2c_next;
            s2d_reg <= s2d_next;

            cmd3_reg <= cmd2_reg;
            dx1_3_reg <= dx1_2_reg;
            dy1_3_reg <= dy1_2_reg;
            dx2_3_reg <= dx2_2_reg;
            dy2_3_reg <= dy2_2_reg;
            det3_reg <= det3_next;
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            e1a_reg <= e1a_next;
            e1b_reg <= e1b_next;
            e2a_reg <= e2a_next;
            e2b_reg <= e2b_next;

            cmd4_reg <= cmd3_reg;
            det4_reg <= det3_reg;
            f1a_reg <= f1a_next;
            f1b_reg <= f1b_next;
            f2a_reg <= f2a_next;
            f2b_reg <= f2b_next;
            nxa_reg <= nxa_next;
            nxb_reg <= nxb_next;
            nya_reg <= nya_next;
            nyb_reg <= nyb_next;

            hit5_reg <= hit5_next;
            det5_reg <= det4_reg;
            numx_reg <= numx_next;
            numy_reg <= numy_next;

            dmag_reg <= dmag_next;
            lane_x_reg <= lane_x_next;
            lane_y_reg <= lane_y_next;
        end
    end

    assign ctrl = ctrl_reg;
    assign dmag = dmag_reg;
    assign lane_x = lane_x_reg;
    assign lane_y = lane_y_reg;

endmodule

FILE: rtl/core/lsi_div_step.sv
// One stage of the pipelined restoring divider: one quotient bit for each coordinate.
// Depends on lsi_pkg.
module lsi_div_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  lsi_pkg::ctrl_t ctrl_in,
    input  lsi_pkg::dmag_t dmag_in,
    input  lsi_pkg::lane_t lane_x_in,
    input  lsi_pkg::lane_t lane_y_in,
    output lsi_pkg::ctrl_t ctrl_out,
    output lsi_pkg::dmag_t dmag_out,
    output lsi_pkg::lane_t lane_x_out,
    output lsi_pkg::lane_t lane_y_out
);
    import lsi_pkg::*;

    ctrl_t ctrl_reg;
    dmag_t dmag_reg;
    lane_t lane_x_reg, lane_y_reg, lane_x_next, lane_y_next;

    function automatic lane_t step(lane_t a, dmag_t d);
        logic [DET_W:0] t;
        logic [DET_W:0] t2;
        lane_t r;
        r = a;
        t = {a.rem, a.low[POINT_BITS-1]};
        t2 = t - {1'b0, d};
        r.low = {a.low[POINT_BITS-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            r.rem = t2[DET_W-1:0];
            r.quo = {a.quo[POINT_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[DET_W-1:0];
            r.quo = {a.quo[POINT_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        lane_x_next = step(lane_x_in, dmag_in);
        lane_y_next = step(lane_y_in, dmag_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (adv)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmag_reg <= dmag_in;
            lane_x_reg <= lane_x_next;
            lane_y_reg <= lane_y_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign dmag_out = dmag_reg;
    assign lane_x_out = lane_x_reg;
    assign lane_y_out = lane_y_reg;

endmodule

FILE: rtl/core/line_segment_intersection.sv
// Top level of the line segment intersection block: front pipeline, divider chain, output stage.
// Depends on lsi_pkg, lsi_prep and lsi_div_step.
//
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | command, first_*, second_* coordinates
//   output  | out_valid / out_ready| hit, point_x, point_y, saturated
//
// One transaction is accepted per cycle while the output is not stalled; the front pipeline is followed
// by the one-bit-per-stage divider chain and the output stage.
// Reset clears only the valid bits of every stage and the hit bits carried with them in the control words.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
module line_segment_intersection (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  lsi_pkg::coord_t     first_start_x,
    input  lsi_pkg::coord_t     first_start_y,
    input  lsi_pkg::coord_t     first_end_x,
    input  lsi_pkg::coord_t     first_end_y,
    input  lsi_pkg::coord_t     second_start_x,
    input  lsi_pkg::coord_t     second_start_y,
    input  lsi_pkg::coord_t     second_end_x,
    input  lsi_pkg::coord_t     second_end_y,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic signed [lsi_pkg::POINT_BITS-1:0] point_x,
    output logic signed [lsi_pkg::POINT_BITS-1:0] point_y,
    output logic                saturated
);
    import lsi_pkg::*;

    logic  adv;
    ctrl_t ctrl_s [0:POINT_BITS];
    dmag_t dmag_s [0:POINT_BITS];
    lane_t lane_x_s [0:POINT_BITS];
    lane_t lane_y_s [0:POINT_BITS];

    logic   out_valid_reg, hit_reg, sat_reg;
    point_t px_reg, py_reg;
    logic   hit_next, sat_next, sat_x, sat_y;
    point_t px_next, py_next, qx, qy;

    function automatic point_t finish(lane_t a, output logic sat);
        point_t lim;
        point_t qm;
        lim = {1'b0, {(POINT_BITS-1){1'b1}}} + point_t'(a.neg);
        sat = a.ovf || (a.quo > lim);
        qm = sat ? lim : a.quo;
        return a.neg ? point_t'(-qm) : qm;
    endfunction

    assign adv = !out_valid_reg || out_ready;
    assign in_ready = adv;

    lsi_prep u_prep (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (in_valid),
        .command        (command),
        .first_start_x  (first_start_x),
        .first_start_y  (first_start_y),
        .first_end_x    (first_end_x),
        .first_end_y    (first_end_y),
        .second_start_x (second_start_x),
        .second_start_y (second_start_y),
        .second_end_x   (second_end_x),
        .second_end_y   (second_end_y),
        .ctrl           (ctrl_s[0]),
        .dmag           (dmag_s[0]),
        .lane_x         (lane_x_s[0]),
        .lane_y         (lane_y_s[0])
    );

    for (genvar i = 0; i < POINT_BITS; i++)
    begin : g_div
        lsi_div_step u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .ctrl_in    (ctrl_s[i]),
            .dmag_in    (dmag_s[i]),
            .lane_x_in  (lane_x_s[i]),
            .lane_y_in  (lane_y_s[i]),
            .ctrl_out   (ctrl_s[i+1]),
            .dmag_out   (dmag_s[i+1]),
            .lane_x_out (lane_x_s[i+1]),
            .lane_y_out (lane_y_s[i+1])
        );
    end

    always_comb
    begin
        qx = finish(lane_x_s[POINT_BITS], sat_x);
        qy = finish(lane_y_s[POINT_BITS], sat_y);
        hit_next = ctrl_s[POINT_BITS].hit;
        px_next = hit_next ? qx : '0;
        py_next = hit_next ? qy : '0;
        sat_next = hit_next && (sat_x || sat_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctrl_s[POINT_BITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
            px_reg <= px_next;
            py_reg <= py_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit = hit_reg;
    assign point_x = px_reg;
    assign point_y = py_reg;
    assign saturated = sat_reg;

endmodule

FILE: rtl/core/lsi_checker.sv
// Port-level checker of the line segment intersection block, bound to the top level.
// Depends on lsi_pkg and line_segment_intersection_defines.svh.
`include "line_segment_intersection_defines.svh"

module lsi_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                hit,
    input logic [lsi_pkg::POINT_BITS-1:0] point_x,
    input logic [lsi_pkg::POINT_BITS-1:0] point_y,
    input logic                saturated
);
    import lsi_pkg::*;

    `LSI_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(point_x) && $stable(point_y) && $stable(saturated), "output transaction changed while stalled")
    `LSI_ASSERT(a_miss_zero, clk, rst_n, out_valid && !hit |-> point_x == '0 && point_y == '0 && !saturated, "miss carries a nonzero point")
    `LSI_ASSERT(a_sat_hit, clk, rst_n, out_valid && saturated |-> hit, "saturation flagged on a miss")
    `LSI_ASSERT(a_ready, clk, rst_n, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")

endmodule

bind line_segment_intersection lsi_checker u_lsi_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for line_segment_intersection: directed cases, then random traffic.
// Depends on lsi_pkg and the line_segment_intersection RTL; expected crossings come from the
// typed directed rows' own results, else from an internal exact-arithmetic predictor.
module testbench;

    import lsi_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [POINT_BITS-1:0] fixed_t;

    typedef struct packed {
        logic [1:0] cmd;
        coord_t     x1, y1, x2, y2, x3, y3, x4, y4;
    } line_pair_t;

    typedef struct packed {
        logic   hit;
        fixed_t px;
        fixed_t py;
        logic   sat;
    } crossing_t;

    typedef struct {
        line_pair_t pair;
        logic       typed;
        crossing_t  result;
    } directed_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    coord_t     first_start_x, first_start_y, first_end_x, first_end_y;
    coord_t     second_start_x, second_start_y, second_end_x, second_end_y;
    logic       out_valid;
    logic       out_ready;
    logic       hit;
    fixed_t     point_x, point_y;
    logic       saturated;

    crossing_t     pending_crossings[$];
    directed_row_t directed_rows[$];
    int            error_count = 0;
    int            results_seen = 0;
    int            hits_seen = 0;
    int            saturations_seen = 0;
    int            items_sent = 0;
    logic          hold_request = 1'b0;
    logic          hold_done = 1'b0;

    line_segment_intersection dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .first_start_x(first_start_x), .first_start_y(first_start_y),
        .first_end_x(first_end_x), .first_end_y(first_end_y),
        .second_start_x(second_start_x), .second_start_y(second_start_y),
        .second_end_x(second_end_x), .second_end_y(second_end_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .point_x(point_x), .point_y(point_y), .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic fixed_t clip_point(input wide_t q, inout logic sat);
        wide_t top;
        wide_t bottom;
        top = (wide_t'(1) <<< (POINT_BITS - 1)) - 1;
        bottom = -(wide_t'(1) <<< (POINT_BITS - 1));
        if (q > top)
        begin
            sat = 1'b1;
            return fixed_t'(top);
        end
        if (q < bottom)
        begin
            sat = 1'b1;
            return fixed_t'(bottom);
        end
        return fixed_t'(q);
    endfunction

    function automatic logic strictly_same_side(input longint a, input longint b);
        return (a > 0 && b > 0) || (a < 0 && b < 0);
    endfunction

    function automatic crossing_t predict_crossing(input line_pair_t p);
        longint    x1, y1, x2, y2, x3, y3, x4, y4;
        longint    dx1, dy1, dx2, dy2, det, c1, c2;
        wide_t     num_x, num_y;
        logic      sat;
        crossing_t r;
        x1 = $signed(p.x1); y1 = $signed(p.y1); x2 = $signed(p.x2); y2 = $signed(p.y2);
        x3 = $signed(p.x3); y3 = $signed(p.y3); x4 = $signed(p.x4); y4 = $signed(p.y4);
        dx1 = x1 - x2; dy1 = y1 - y2; dx2 = x3 - x4; dy2 = y3 - y4;
        det = dx1 * dy2 - dy1 * dx2;
        c1 = x1 * y2 - y1 * x2;
        c2 = x3 * y4 - y3 * x4;
        r = '0;
        sat = 1'b0;
        if (det == 0)
            return r;
        if ((p.cmd == CMD_SEG_SEG || p.cmd == CMD_SEG_LINE) &&
            strictly_same_side(dy2 * x1 - dx2 * y1 + c2, dy2 * x2 - dx2 * y2 + c2))
            return r;
        if (p.cmd == CMD_SEG_SEG &&
            strictly_same_side(dy1 * x3 - dx1 * y3 + c1, dy1 * x4 - dx1 * y4 + c1))
            return r;
        num_x = (wide_t'(c1) * wide_t'(dx2) - wide_t'(dx1) * wide_t'(c2)) <<< FRAC_BITS;
        num_y = (wide_t'(c1) * wide_t'(dy2) - wide_t'(dy1) * wide_t'(c2)) <<< FRAC_BITS;
        r.hit = 1'b1;
        r.px = clip_point(num_x / wide_t'(det), sat);
        r.py = clip_point(num_y / wide_t'(det), sat);
        r.sat = sat;
        return r;
    endfunction

    function automatic line_pair_t make_pair(input logic [1:0] cmd, input int x1, input int y1,
                                             input int x2, input int y2, input int x3,
                                             input int y3, input int x4, input int y4);
        line_pair_t p;
        p.cmd = cmd;
        p.x1 = coord_t'(x1); p.y1 = coord_t'(y1); p.x2 = coord_t'(x2); p.y2 = coord_t'(y2);
        p.x3 = coord_t'(x3); p.y3 = coord_t'(y3); p.x4 = coord_t'(x4); p.y4 = coord_t'(y4);
        return p;
    endfunction

    task automatic add_row(input line_pair_t p, input logic typed, input logic h,
                           input longint px, input longint py, input logic s);
        directed_row_t row;
        row.pair = p;
        row.typed = typed;
        row.result.hit = h;
        row.result.px = fixed_t'(px);
        row.result.py = fixed_t'(py);
        row.result.sat = s;
        directed_rows.push_back(row);
    endtask

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic offer_pair(input line_pair_t p, input crossing_t expected);
        in_valid <= 1'b1;
        command <= p.cmd;
        first_start_x <= p.x1; first_start_y <= p.y1;
        first_end_x <= p.x2; first_end_y <= p.y2;
        second_start_x <= p.x3; second_start_y <= p.y3;
        second_end_x <= p.x4; second_end_y <= p.y4;
        do
            @(posedge clk);
        while (!in_ready);
        pending_crossings.push_back(expected);
        items_sent++;
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic coord_t random_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
            1, 2: return coord_t'($signed($urandom_range(0, 16)) - 8);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic line_pair_t random_pair();
        line_pair_t p;
        int         bx, by, ex, ey, ox, oy;
        p.cmd = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0:
            begin
                p.x1 = coord_t'($urandom); p.y1 = coord_t'($urandom);
                p.x2 = coord_t'($urandom); p.y2 = coord_t'($urandom);
                p.x3 = coord_t'($urandom); p.y3 = coord_t'($urandom);
                p.x4 = coord_t'($urandom); p.y4 = coord_t'($urandom);
            end
            1:
            begin
                // Nearly parallel lines can cross far away and drive the point into saturation.
                bx = $signed($urandom_range(0, 2000)) - 1000;
                by = $signed($urandom_range(0, 2000)) - 1000;
                ex = $urandom_range(1000, 32000);
                ey = $signed($urandom_range(0, 64000)) - 32000;
                ox = $signed($urandom_range(0, 8)) - 4;
                oy = $signed($urandom_range(0, 8)) - 4;
                p = make_pair(p.cmd, bx, by, bx + ex, by + ey, bx + ox, by + oy,
                              bx + ex + $signed($urandom_range(0, 2)) - 1, by + ey + oy);
            end
            default:
            begin
                p.x1 = random_coord(); p.y1 = random_coord();
                p.x2 = random_coord(); p.y2 = random_coord();
                p.x3 = random_coord(); p.y3 = random_coord();
                p.x4 = random_coord(); p.y4 = random_coord();
            end
        endcase
        return p;
    endfunction

    always @(posedge clk)
    begin
        crossing_t expected;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_crossings.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result hit=%0b x=%0d y=%0d sat=%0b",
                         $time, hit, point_x, point_y, saturated);
            end
            else
            begin
                expected = pending_crossings.pop_front();
                if (expected.hit) hits_seen++;
                if (expected.sat) saturations_seen++;
                if (hit !== expected.hit)
                begin
                    error_count++;
                    $display("%0t: hit expected %0b actual %0b", $time, expected.hit, hit);
                end
                if (point_x !== expected.px)
                begin
                    error_count++;
                    $display("%0t: point_x expected %0d actual %0d", $time, expected.px, point_x);
                end
                if (point_y !== expected.py)
                begin
                    error_count++;
                    $display("%0t: point_y expected %0d actual %0d", $time, expected.py, point_y);
                end
                if (saturated !== expected.sat)
                begin
                    error_count++;
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, expected.sat, saturated);
                end
            end
        end
    end

    initial
    begin
        int stall_chance;
        int phase_left;
        out_ready = 1'b0;
        stall_chance = 0;
        phase_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_done = 1'b1;
                out_ready <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(10, 80);
                    stall_chance = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
                end
                phase_left--;
                out_ready <= ($urandom_range(1, 100) > stall_chance);
            end
        end
    end

    initial
    begin
        int         burst_left;
        line_pair_t p;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_SEG_SEG;
        {first_start_x, first_start_y, first_end_x, first_end_y} = '0;
        {second_start_x, second_start_y, second_end_x, second_end_y} = '0;

        add_row(make_pair(CMD_SEG_SEG, -1, 0, 1, 0, 0, -1, 0, 1), 1, 1, 0, 0, 0);
        add_row(make_pair(CMD_SEG_SEG, 0, 0, 2, 2, 0, 2, 2, 0), 1, 1, 65536, 65536, 0);
        add_row(make_pair(CMD_SEG_SEG, 0, 0, 4, 0, 4, 0, 4, 4), 1, 1, 262144, 0, 0);
        add_row(make_pair(CMD_SEG_SEG, 0, 0, 4, 0, 0, 1, 4, 1), 1, 0, 0, 0, 0);
        add_row(make_pair(CMD_LINE_LINE, 0, 0, 4, 4, 1, 1, 3, 3), 1, 0, 0, 0, 0);
        add_row(make_pair(CMD_LINE_LINE, 5, 5, 5, 5, -3, 2, 7, 1), 1, 0, 0, 0, 0);
        add_row(make_pair(CMD_SEG_SEG, 0, 0, 1, 0, 5, -1, 5, 1), 1, 0, 0, 0, 0);
        add_row(make_pair(CMD_SEG_LINE, 0, 0, 1, 0, 5, -1, 5, 1), 1, 0, 0, 0, 0);
        add_row(make_pair(CMD_LINE_LINE, 0, 0, 1, 0, 5, -1, 5, 1), 1, 1, 327680, 0, 0);
        add_row(make_pair(CMD_SEG_SEG, 0, -5, 0, 5, -3, 0, -1, 0), 1, 0, 0, 0, 0);
        add_row(make_pair(CMD_SEG_LINE, 0, -5, 0, 5, -3, 0, -1, 0), 1, 1, 0, 0, 0);
        add_row(make_pair(2'd3, 0, 0, 1, 0, 5, -1, 5, 1), 1, 1, 327680, 0, 0);
        add_row(make_pair(CMD_SEG_SEG, -32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768), 1, 0, 0, 0, 0);
        add_row(make_pair(CMD_SEG_SEG, 32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767), 1, 0, 0, 0, 0);
        add_row(make_pair(CMD_SEG_SEG, -32768, -32768, 32767, 32767, -32768, 32767,
                          32767, -32768), 0, 0, 0, 0, 0);
        add_row(make_pair(CMD_LINE_LINE, -32768, 0, 32767, 1, -32768, 1, 32767, 1),
                0, 0, 0, 0, 0);
        add_row(make_pair(CMD_LINE_LINE, -32768, -32768, 32767, 32766, -32768, -32767,
                          32767, 32767), 0, 0, 0, 0, 0);
        add_row(make_pair(CMD_LINE_LINE, 32767, -32768, -32768, 32767, 32767, -32767,
                          -32768, 32766), 0, 0, 0, 0, 0);
        add_row(make_pair(CMD_SEG_LINE, 3, -7, -2, 9, -30000, 12, 31000, -5), 0, 0, 0, 0, 0);
        add_row(make_pair(CMD_SEG_SEG, 1, 1, 7, 3, 2, 5, 6, -4), 0, 0, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_pair(directed_rows[i].pair, directed_rows[i].typed ?
                       directed_rows[i].result : predict_crossing(directed_rows[i].pair));
            idle_for($urandom_range(0, 1) * $urandom_range(0, 3));
        end

        burst_left = 0;
        for (int n = 0; n < 650; n++)
        begin
            if (n == 150)
                hold_request = 1'b1;
            if (n == 400)
            begin
                in_valid <= 1'b0;
                while (pending_crossings.size() != 0)
                    @(posedge clk);
            end
            p = random_pair();
            offer_pair(p, predict_crossing(p));
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            end
            else
                burst_left--;
        end
        in_valid <= 1'b0;

        while (pending_crossings.size() != 0)
            @(posedge clk);
        repeat (7 + POINT_BITS + 20) @(posedge clk);

        $display("Sent %0d transactions, checked %0d results: %0d hits, %0d saturated.",
                 items_sent, results_seen, hits_seen, saturations_seen);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
